/* sv/tmav_pkg.sv */
// Package for the trimmed moving average voltage block.
// Holds the fixed field widths, stream widths and register reset value.
// No dependencies.
`default_nettype none

package tmav_pkg;

    localparam int SAMPLE_W     = 10;
    localparam int GAIN_W       = 18;
    localparam int MV_W         = 16;
    localparam int TRIM_W       = 14;
    localparam int IN_TDATA_W   = 16;
    localparam int OUT_TDATA_W  = 32;
    localparam int OUT_TUSER_W  = 1;
    localparam int FRAC_BITS    = 16;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 18'd73254;
    localparam logic [MV_W-1:0]   MV_MAX     = 16'hFFFF;

endpackage

`default_nettype wire

/* sv/trimmed_moving_average_voltage.sv */
// Trimmed moving average of battery ADC samples, scaled to millivolts.
// Depends on tmav_pkg for field widths and the gain reset value.
//
// Channel   Direction  Beat contents (lowest bit first)
// s_axis    in         tdata: battery_sample[9:0], zero fill to 16 bits
// m_axis    out        tdata: voltage_mv[15:0], trimmed_sum[29:16], zero fill;
//                      tuser: average_valid
// cfg       in         mv_gain[17:0], written whenever i_cfg_wr_en is high
//
// An accepted beat is scanned one ring entry at a time through a single max/min
// compare pair, then goes through a trim subtract and a gain multiply before its
// result is loaded. The block accepts the next beat only after that load, once
// it is back in the idle state.
// Reset clears the ring, the running sum and the warm-up count at once.
// A result waiting in the output register stalls only the final load step.
`default_nettype none

module trimmed_moving_average_voltage #(
    parameter int WINDOW   = 10,
    parameter int WARMUP   = 14,
    parameter int ADC_BITS = 10
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // battery_sample[9:0], zeros above
    input  wire logic [tmav_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // voltage_mv[15:0], trimmed_sum[29:16], zeros above
    output logic [tmav_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
    // average_valid
    output logic [tmav_pkg::OUT_TUSER_W-1:0]         m_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [tmav_pkg::GAIN_W-1:0]         i_cfg_wr_data
);
    import tmav_pkg::*;

    localparam int EW     = ADC_BITS + 1;
    localparam int IDX_W  = $clog2(WINDOW);
    localparam int SUM_W  = $clog2(WINDOW * ((2 ** EW) - 1) + 1);
    localparam int PROD_W = SUM_W + GAIN_W;
    localparam int RW     = (PROD_W + 1 > 2 * FRAC_BITS + 1) ? PROD_W + 1 : 2 * FRAC_BITS + 1;
    localparam int SEEN_W = $clog2(WARMUP + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_TRIM,
        S_MUL,
        S_DONE
    } t_state;

    t_state                 r_state;
    logic [EW-1:0]          r_ring [WINDOW];
    logic [IDX_W-1:0]       r_slot;
    logic [IDX_W-1:0]       r_idx;
    logic [SUM_W-1:0]       r_sum;
    logic [SEEN_W-1:0]      r_seen;
    logic [GAIN_W-1:0]      r_gain;
    logic [EW-1:0]          r_new;
    logic [EW-1:0]          r_max;
    logic [EW-1:0]          r_min;
    logic [SUM_W-1:0]       r_trim;
    logic [PROD_W-1:0]      r_prod;
    logic                   r_valid_flag;
    logic [MV_W-1:0]        r_mv;
    logic [TRIM_W-1:0]      r_trim_out;
    logic                   r_avg_valid;
    logic                   r_out_valid;

    logic [ADC_BITS+SAMPLE_W-1:0] raw_ext;
    logic [EW-1:0]          n_new;
    logic [SEEN_W-1:0]      n_seen;
    logic [EW-1:0]          scan_val;
    logic                   scan_hit;
    logic [RW-1:0]          rounded;
    logic                   mv_sat;
    logic [SUM_W+TRIM_W-1:0] trim_ext;
    logic                   in_beat;
    logic                   out_beat;
    logic                   load_out;

    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign out_beat      = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign load_out      = (r_state == S_DONE) && (!r_out_valid || m_axis_tready);

    // Only the low ADC_BITS bits of the sample count; the entry is 2*raw+1.
    assign raw_ext = {{ADC_BITS{1'b0}}, s_axis_tdata[SAMPLE_W-1:0]};
    assign n_new   = {raw_ext[ADC_BITS-1:0], 1'b1};
    assign n_seen  = (r_seen < SEEN_W'(WARMUP)) ? r_seen + 1'b1 : r_seen;

    // The entry being replaced takes part in the search with its new value.
    assign scan_hit = (r_idx == r_slot);
    assign scan_val = scan_hit ? r_new : r_ring[r_idx];

    assign rounded  = RW'(r_prod) + RW'(1 << (FRAC_BITS - 1));
    assign mv_sat   = |rounded[RW-1:2*FRAC_BITS];
    assign trim_ext = {{TRIM_W{1'b0}}, r_trim};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_slot      <= '0;
            r_idx       <= '0;
            r_sum       <= '0;
            r_seen      <= '0;
            r_gain      <= GAIN_RESET;
            r_out_valid <= 1'b0;
            for (int i = 0; i < WINDOW; i++) begin
                r_ring[i] <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_gain <= i_cfg_wr_data;
            end
            // A new result can replace the one taken in the same cycle.
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (out_beat) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_beat) begin
                        r_new        <= n_new;
                        r_seen       <= n_seen;
                        r_valid_flag <= (n_seen >= SEEN_W'(WARMUP));
                        r_idx        <= '0;
                        r_state      <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_idx == '0) begin
                        r_max <= scan_val;
                        r_min <= scan_val;
                    end else begin
                        if (scan_val > r_max) r_max <= scan_val;
                        if (scan_val < r_min) r_min <= scan_val;
                    end
                    if (scan_hit) begin
                        r_sum         <= r_sum - SUM_W'(r_ring[r_idx]) + SUM_W'(r_new);
                        r_ring[r_idx] <= r_new;
                    end
                    if (r_idx == IDX_W'(WINDOW - 1)) begin
                        r_slot  <= (r_slot == IDX_W'(WINDOW - 1)) ? '0 : r_slot + 1'b1;
                        r_state <= S_TRIM;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_TRIM: begin
                    r_trim  <= r_sum - SUM_W'(r_max) - SUM_W'(r_min);
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= PROD_W'(r_trim) * PROD_W'(r_gain);
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (load_out) begin
                        r_avg_valid <= r_valid_flag;
                        if (r_valid_flag) begin
                            r_mv       <= mv_sat ? MV_MAX : rounded[2*FRAC_BITS-1:FRAC_BITS];
                            r_trim_out <= trim_ext[TRIM_W-1:0];
                        end else begin
                            r_mv       <= '0;
                            r_trim_out <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W - MV_W - TRIM_W){1'b0}}, r_trim_out, r_mv};
    assign m_axis_tuser  = r_avg_valid;

    // An accepted beat keeps the input closed for the whole scan.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> !s_axis_tready)
        else $error("input accepted while the previous beat is in work");

    // Results before warm-up carry zero payload.
    a_zero_before_warmup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("payload nonzero before warm-up");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (int'(r_idx) < WINDOW))
        else $error("scan index beyond the ring");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_slot) < WINDOW)
        else $error("write slot beyond the ring");

    // A pending result is never overwritten before it is taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("pending result lost");

    a_seen_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= SEEN_W'(WARMUP))
        else $error("warm-up count past its limit");

endmodule

`default_nettype wire

/* verif/tb_trimmed_moving_average_voltage.sv */
// Self-checking testbench for the trimmed moving average voltage block.
// A scoreboard class predicts every result beat from the accepted samples and gain.
// Depends on tmav_pkg and trimmed_moving_average_voltage.
`timescale 1ns / 100ps

module tb_trimmed_moving_average_voltage;

    import tmav_pkg::*;

    localparam int WINDOW        = 10;
    localparam int WARMUP        = 14;
    localparam int ADC_BITS      = 10;
    localparam int SETTLE_CYCLES = 2 * (WINDOW + 4);
    localparam int PHASE_ITEMS   = 150;
    localparam int HOLD_CYCLES   = 300;

    typedef struct packed {
        logic [MV_W-1:0]   mv;
        logic [TRIM_W-1:0] trim;
        logic              valid;
    } t_reading;

    // Tracks the ring of half-count samples and the gain, and queues the reading that
    // each accepted sample should produce.
    class tmav_scoreboard;
        logic [ADC_BITS:0]   ring [WINDOW];
        int unsigned         slot;
        logic [14:0]         window_sum;
        int unsigned         warm_count;
        logic [GAIN_W-1:0]   gain;
        t_reading            expected_readings [$];
        int unsigned         errors;

        function new();
            foreach (ring[i]) ring[i] = '0;
            slot       = 0;
            window_sum = '0;
            warm_count = 0;
            gain       = GAIN_RESET;
            errors     = 0;
        endfunction

        function void set_gain(logic [GAIN_W-1:0] g);
            gain = g;
        endfunction

        function int unsigned pending();
            return expected_readings.size();
        endfunction

        function void note_sample(logic [SAMPLE_W-1:0] raw);
            logic [ADC_BITS:0] half_counts;
            logic [ADC_BITS:0] hi;
            logic [ADC_BITS:0] lo;
            logic [14:0]       trim;
            longint unsigned   scaled;
            t_reading          r;

            half_counts = {raw[ADC_BITS-1:0], 1'b1};
            window_sum  = window_sum - 15'(ring[slot]) + 15'(half_counts);
            ring[slot]  = half_counts;
            slot        = (slot == WINDOW - 1) ? 0 : slot + 1;
            if (warm_count < WARMUP) warm_count++;

            hi = ring[0];
            lo = ring[0];
            for (int i = 1; i < WINDOW; i++) begin
                if (ring[i] > hi) hi = ring[i];
                if (ring[i] < lo) lo = ring[i];
            end
            trim   = window_sum - 15'(hi) - 15'(lo);
            scaled = (64'(trim) * 64'(gain) + 64'd32768) >> FRAC_BITS;
            if (scaled > 64'(MV_MAX)) scaled = 64'(MV_MAX);

            // Until warm-up completes the block reports an all-zero reading.
            if (warm_count >= WARMUP) begin
                r.mv    = scaled[MV_W-1:0];
                r.trim  = trim[TRIM_W-1:0];
                r.valid = 1'b1;
            end else begin
                r = '0;
            end
            expected_readings.push_back(r);
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic [OUT_TDATA_W-1:0] data, logic [OUT_TUSER_W-1:0] user);
            t_reading r;

            if (expected_readings.size() == 0) begin
                report_mismatch($sformatf("result beat 0x%08h with none pending", data));
                return;
            end
            r = expected_readings.pop_front();
            if (data[MV_W-1:0] !== r.mv)
                report_mismatch($sformatf("voltage_mv %0d, wanted %0d",
                                          data[MV_W-1:0], r.mv));
            if (data[MV_W +: TRIM_W] !== r.trim)
                report_mismatch($sformatf("trimmed_sum %0d, wanted %0d",
                                          data[MV_W +: TRIM_W], r.trim));
            if (user[0] !== r.valid)
                report_mismatch($sformatf("average_valid %0b, wanted %0b", user[0], r.valid));
            if (data[OUT_TDATA_W-1:MV_W+TRIM_W] !== '0)
                report_mismatch($sformatf("nonzero fill bits in 0x%08h", data));
        endtask
    endclass

    logic                       i_clk;
    logic                       i_rst_n;
    logic [IN_TDATA_W-1:0]      s_axis_tdata;
    logic                       s_axis_tvalid;
    logic                       s_axis_tready;
    logic [OUT_TDATA_W-1:0]     m_axis_tdata;
    logic [OUT_TUSER_W-1:0]     m_axis_tuser;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready;
    logic                       i_cfg_wr_en;
    logic [GAIN_W-1:0]          i_cfg_wr_data;

    tmav_scoreboard             sb;
    int unsigned                send_idle_pct;
    int unsigned                recv_idle_pct;
    logic                       hold_req;
    int unsigned                hold_left;
    int                         level;
    logic [SAMPLE_W-1:0]        last_sample;

    logic [SAMPLE_W-1:0] directed_samples [25] = '{
        10'd1, 10'd2, 10'd4, 10'd8, 10'd16, 10'd32, 10'd64, 10'd128, 10'd256, 10'd512,
        10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023,
        10'd0, 10'd0, 10'd0, 10'd0,
        10'd1023, 10'd0, 10'd1023, 10'd0, 10'd341
    };

    trimmed_moving_average_voltage #(
        .WINDOW   (WINDOW),
        .WARMUP   (WARMUP),
        .ADC_BITS (ADC_BITS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Result side: check each accepted beat, then pick the next ready level.
    always @(posedge i_clk) begin
        if (m_axis_tvalid === 1'b1 && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Full-range values most often, then a slowly drifting battery level with noise,
    // which produces ties, and then rail values and straight repeats.
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int unsigned sel;
        int          v;

        sel = $urandom_range(99);
        if (sel < 40) return SAMPLE_W'($urandom_range(1023));
        if (sel < 70) begin
            level = level + $urandom_range(8) - 4;
            if (level < 0) level = 0;
            if (level > 1023) level = 1023;
            v = level + $urandom_range(4) - 2;
            if (v < 0) v = 0;
            if (v > 1023) v = 1023;
            return SAMPLE_W'(v);
        end
        if (sel < 85) return $urandom_range(1) ? 10'd1023 : 10'd0;
        return last_sample;
    endfunction

    task send_sample(logic [SAMPLE_W-1:0] raw);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'(raw);
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_sample(raw);
        last_sample = raw;
    endtask

    // Stops offering beats and waits until every pending reading has been checked.
    task drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task write_gain(logic [GAIN_W-1:0] g);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= g;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.set_gain(g);
    endtask

    initial begin
        logic [GAIN_W-1:0] phase_gains [7];

        sb            = new();
        i_rst_n       = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tvalid = 1'b0;
        m_axis_tready = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req      = 1'b0;
        hold_left     = 0;
        level         = 600;
        last_sample   = '0;

        phase_gains[0] = '0;
        phase_gains[1] = '1;
        phase_gains[2] = 18'd1;
        phase_gains[3] = GAIN_W'($urandom_range(262143));
        phase_gains[4] = 18'd65536;
        phase_gains[5] = GAIN_RESET;
        phase_gains[6] = GAIN_W'($urandom_range(262143));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part runs with the reset gain and covers warm-up and the rails.
        foreach (directed_samples[i]) send_sample(directed_samples[i]);
        drain();

        for (int phase = 0; phase < 7; phase++) begin
            write_gain(phase_gains[phase]);
            case (phase % 3)
                0: begin
                    send_idle_pct = 22;
                    recv_idle_pct = 46;
                end
                1: begin
                    send_idle_pct = 46;
                    recv_idle_pct = 22;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            // Starve the result side once so the block backs up onto its input.
            if (phase == 2) hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) send_sample(pick_sample());
            drain();
        end

        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
sv/tmav_pkg.sv
sv/trimmed_moving_average_voltage.sv
verif/tb_trimmed_moving_average_voltage.sv
